### hw/rtl/stir_pkg.sv
package stir_pkg;

   localparam int SLOTS     = 128;
   localparam int ROLE_BITS = 8;
   localparam int ID_BITS   = 16;

   localparam logic CMD_LOGIN  = 1'b0;
   localparam logic CMD_LOGOUT = 1'b1;

   // operation broadcast to every cell during one pass
   typedef enum logic [1:0] {
      MODE_SCAN   = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_REMOVE = 2'd2
   } mode_type;

   typedef struct packed {
      logic [ROLE_BITS-1:0] role;
      logic [ID_BITS-1:0]   user_id;
   } key_type;

   // token walking down the chain: done = first hit (on insert, first free cell) already claimed
   typedef struct packed {
      logic valid;
      logic done;
   } token_type;

endpackage

### hw/rtl/stir_req_if.sv
interface stir_req_if;
   import stir_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 command;
   logic [ROLE_BITS-1:0] role;
   logic [ID_BITS-1:0]   user_id;

   modport source (output valid, output command, output role, output user_id, input ready);
   modport sink   (input valid, input command, input role, input user_id, output ready);
endinterface

### hw/rtl/stir_rsp_if.sv
interface stir_rsp_if;
   logic valid;
   logic ready;
   logic accepted;

   modport source (output valid, output accepted, input ready);
   modport sink   (input valid, input accepted, output ready);
endinterface

### hw/rtl/session_table_insert_remove.sv
// Session table: SLOTS cells in a row, one session (valid, role, user id) per cell.
// Each word on req is a login (command 0) or logout (command 1). A login returns one
// word on rsp: accepted 1 when it took the lowest free slot, 0 when the same role and
// user is already active or the table is full. A logout clears the lowest active
// matching slot and returns nothing. Work is done by a token that moves one cell per
// cycle while the key and operation are broadcast to all cells, so the cost is set by
// the chain length: a logout takes one pass, a refused duplicate one pass, and any
// other login two passes (duplicate scan, then insert pass). One word is in work at a
// time; the next is taken as soon as the result sits in the output register, even if
// rsp has not taken it yet. The table is empty after reset, with no clearing pass.
module session_table_insert_remove (
   input  logic       clock,
   input  logic       reset,
   stir_req_if.sink   req,
   stir_rsp_if.source rsp
);
   import stir_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PASS,    // token travelling down the chain
      ST_RESULT   // login result waiting for the output register
   } state_type;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   key_type   key_ff, key_in;
   token_type head_ff, head_in;
   logic      res_ff, res_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_acc_ff, rsp_acc_in;

   token_type tok_chain [SLOTS+1];
   token_type tail;

   assign tok_chain[0] = head_ff;
   assign tail         = tok_chain[SLOTS];

   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      stir_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .mode     (mode_ff),
         .key      (key_ff),
         .tok_prev (tok_chain[k]),
         .tok_next (tok_chain[k+1])
      );
   end

   assign req.ready    = (state_ff == ST_IDLE);
   assign rsp.valid    = rsp_valid_ff;
   assign rsp.accepted = rsp_acc_ff;

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      head_in      = '0;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_acc_in   = rsp_acc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               key_in.role    = req.role;
               key_in.user_id = req.user_id;
               mode_in        = (req.command == CMD_LOGOUT) ? MODE_REMOVE : MODE_SCAN;
               head_in.valid  = 1'b1;
               state_in       = ST_PASS;
            end
         end
         ST_PASS: begin
            if (tail.valid) begin
               unique case (mode_ff)
                  MODE_REMOVE: begin
                     state_in = ST_IDLE;
                  end
                  MODE_SCAN: begin
                     if (tail.done) begin
                        // already logged in
                        res_in   = 1'b0;
                        state_in = ST_RESULT;
                     end else begin
                        mode_in       = MODE_INSERT;
                        head_in.valid = 1'b1;
                     end
                  end
                  MODE_INSERT: begin
                     // done means some cell took the entry; else table full
                     res_in   = tail.done;
                     state_in = ST_RESULT;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_SCAN;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
      end
      key_ff     <= key_in;
      res_ff     <= res_in;
      rsp_acc_ff <= rsp_acc_in;
   end

endmodule

### hw/rtl/stir_cell.sv
module stir_cell (
   input  logic                clock,
   input  logic                reset,
   input  stir_pkg::mode_type  mode,
   input  stir_pkg::key_type   key,
   input  stir_pkg::token_type tok_prev,
   output stir_pkg::token_type tok_next
);
   import stir_pkg::*;

   logic      valid_ff, valid_in;
   key_type   key_ff, key_in;
   token_type tok_ff, tok_in;
   logic      hit;

   assign hit      = valid_ff && (key_ff == key);
   assign tok_next = tok_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      tok_in   = tok_prev;
      if (tok_prev.valid && !tok_prev.done) begin
         unique case (mode)
            MODE_SCAN: begin
               tok_in.done = hit;
            end
            MODE_INSERT: begin
               if (!valid_ff) begin
                  valid_in    = 1'b1;
                  key_in      = key;
                  tok_in.done = 1'b1;
               end
            end
            MODE_REMOVE: begin
               if (hit) begin
                  valid_in    = 1'b0;
                  tok_in.done = 1'b1;
               end
            end
            default: begin
               tok_in = tok_prev;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         tok_ff   <= tok_in;
      end
      key_ff <= key_in;
   end

endmodule
